@@ hdl/skl_pkg.sv @@
package skl_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned HND_W    = 8;
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_INSERT   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FIND     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP      = 3'd3;
  localparam logic [REQ_W-1:0] REQ_NOT_LESS = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [KEY_W-1:0] key;
    logic [HND_W-1:0] handle;
  } skl_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HND_W-1:0]    found_handle;
    logic [KEY_W-1:0]    found_key;
    logic [COUNT_W-1:0]  entry_count;
  } skl_out_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_WNEW = 4'b0100,
    S_FIN  = 4'b1000
  } skl_state_e;

endpackage

@@ hdl/skl_mem.sv @@
module skl_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 40
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/sorted_key_list_engine.sv @@
// Find, delete, pop and find-not-less walk the entries from the head, and insert walks
// from the tail or writes straight into an empty list. Full, empty and unused requests
// skip the walk. A finished request waits in S_FIN until the result register is free.
// One request is in work at a time; the next transfer is taken once the result is
// registered. The single read port walks the entries, one per cycle.
// Reset (rst_ni, asynchronous, active low) empties the list; the memory is not cleared.
module sorted_key_list_engine #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned HANDLE_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  skl_pkg::skl_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output skl_pkg::skl_out_t out_data_o
);

  import skl_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = KEY_W + HANDLE_BITS;

  skl_state_e state_q, state_d;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic [AW-1:0] p_idx_q, p_idx_d;
  logic [AW-1:0] wpos_q, wpos_d;
  logic          issue_q, issue_d;
  logic          p_vld_q, p_vld_d;
  logic          hit_q, hit_d;
  logic          out_valid_q, out_valid_d;

  logic [REQ_W-1:0]       req_q, req_d;
  logic [KEY_W-1:0]       key_q, key_d;
  logic [HANDLE_BITS-1:0] hnd_q, hnd_d;
  logic [STATUS_W-1:0]    res_status_q, res_status_d;
  logic [KEY_W-1:0]       res_key_q, res_key_d;
  logic [HANDLE_BITS-1:0] res_hnd_q, res_hnd_d;
  skl_out_t               out_q, out_d;

  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_waddr;
  logic [EW-1:0]          mem_wdata, mem_rdata;
  logic [KEY_W-1:0]       rd_key;
  logic [HANDLE_BITS-1:0] rd_hnd;
  logic [HANDLE_BITS-1:0] in_hnd;
  logic [HND_W-1:0]       res_hnd_ext;
  logic [COUNT_W-1:0]     cnt_ext;
  logic [AW-1:0]          cnt_last;
  logic                   is_last;
  logic                   key_eq;
  logic                   out_free;

  if (HANDLE_BITS <= HND_W) begin : g_hnd_narrow
    assign in_hnd      = in_data_i.handle[HANDLE_BITS-1:0];
    assign res_hnd_ext = HND_W'(res_hnd_q);
  end else begin : g_hnd_wide
    assign in_hnd      = HANDLE_BITS'(in_data_i.handle);
    assign res_hnd_ext = res_hnd_q[HND_W-1:0];
  end

  if (CW >= COUNT_W) begin : g_cnt_trunc
    assign cnt_ext = cnt_q[COUNT_W-1:0];
  end else begin : g_cnt_ext
    assign cnt_ext = COUNT_W'(cnt_q);
  end

  skl_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_idx_q),
    .rdata_o (mem_rdata)
  );

  assign rd_key   = mem_rdata[EW-1:HANDLE_BITS];
  assign rd_hnd   = mem_rdata[HANDLE_BITS-1:0];
  assign cnt_last = AW'(cnt_q - CW'(1));
  assign is_last  = (p_idx_q == cnt_last);
  assign key_eq   = (rd_key == key_q);
  assign out_free = !out_valid_q || out_ready_i;

  // Reads run ahead of the write of the entry being moved by at least two places, so a
  // read and a write never touch the same entry in one cycle and no forwarding is needed.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rd_idx_d     = rd_idx_q;
    issue_d      = issue_q;
    hit_d        = hit_q;
    wpos_d       = wpos_q;
    req_d        = req_q;
    key_d        = key_q;
    hnd_d        = hnd_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_hnd_d    = res_hnd_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d        = in_data_i.req_type;
          key_d        = in_data_i.key;
          hnd_d        = in_hnd;
          res_status_d = ST_NONE;
          res_key_d    = '0;
          res_hnd_d    = '0;
          hit_d        = 1'b0;
          case (in_data_i.req_type)
            REQ_INSERT: begin
              if (cnt_q == CW'(CAPACITY)) begin
                res_status_d = ST_FULL;
                state_d      = S_FIN;
              end else if (cnt_q == '0) begin
                wpos_d  = '0;
                state_d = S_WNEW;
              end else begin
                // Insert walks from the tail down, moving larger entries up one place.
                rd_idx_d = cnt_last;
                issue_d  = 1'b1;
                state_d  = S_SCAN;
              end
            end
            REQ_FIND, REQ_DELETE, REQ_POP, REQ_NOT_LESS: begin
              if (cnt_q == '0) begin
                state_d = S_FIN;
              end else begin
                rd_idx_d = '0;
                issue_d  = 1'b1;
                state_d  = S_SCAN;
              end
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (issue_q) begin
          mem_re = 1'b1;
          if (req_q == REQ_INSERT) begin
            rd_idx_d = rd_idx_q - AW'(1);
            if (rd_idx_q == '0) begin
              issue_d = 1'b0;
            end
          end else begin
            rd_idx_d = rd_idx_q + AW'(1);
            if (rd_idx_q == cnt_last) begin
              issue_d = 1'b0;
            end
          end
        end

        if (p_vld_q) begin
          case (req_q)
            REQ_INSERT: begin
              if (key_q < rd_key) begin
                mem_we    = 1'b1;
                mem_waddr = p_idx_q + AW'(1);
                mem_wdata = mem_rdata;
                if (p_idx_q == '0) begin
                  wpos_d  = '0;
                  issue_d = 1'b0;
                  state_d = S_WNEW;
                end
              end else begin
                wpos_d  = p_idx_q + AW'(1);
                issue_d = 1'b0;
                state_d = S_WNEW;
              end
            end
            REQ_FIND, REQ_NOT_LESS: begin
              if ((req_q == REQ_FIND) ? key_eq : (key_q <= rd_key)) begin
                res_status_d = ST_OK;
                res_key_d    = rd_key;
                res_hnd_d    = rd_hnd;
                issue_d      = 1'b0;
                state_d      = S_FIN;
              end else if (is_last) begin
                state_d = S_FIN;
              end
            end
            REQ_DELETE, REQ_POP: begin
              // Once the victim is seen, every later entry moves down one place.
              if (hit_q) begin
                mem_we    = 1'b1;
                mem_waddr = p_idx_q - AW'(1);
                mem_wdata = mem_rdata;
              end else if ((req_q == REQ_POP) ? (p_idx_q == '0) : key_eq) begin
                hit_d        = 1'b1;
                res_status_d = ST_OK;
                res_key_d    = rd_key;
                res_hnd_d    = rd_hnd;
              end
              if (is_last) begin
                if (hit_d) begin
                  cnt_d = cnt_q - CW'(1);
                end
                state_d = S_FIN;
              end
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end

      S_WNEW: begin
        mem_we       = 1'b1;
        mem_waddr    = wpos_q;
        mem_wdata    = {key_q, hnd_q};
        cnt_d        = cnt_q + CW'(1);
        res_status_d = ST_OK;
        state_d      = S_FIN;
      end

      S_FIN: begin
        if (out_free) begin
          out_d.status       = res_status_q;
          out_d.found_handle = res_hnd_ext;
          out_d.found_key    = res_key_q;
          out_d.entry_count  = cnt_ext;
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    p_vld_d = mem_re && (state_d == S_SCAN);
    p_idx_d = rd_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      issue_q     <= 1'b0;
      p_vld_q     <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      issue_q     <= issue_d;
      p_vld_q     <= p_vld_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q     <= rd_idx_d;
    p_idx_q      <= p_idx_d;
    wpos_q       <= wpos_d;
    req_q        <= req_d;
    key_q        <= key_d;
    hnd_q        <= hnd_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_hnd_q    <= res_hnd_d;
    out_q        <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_WNEW || (state_q == S_SCAN && p_vld_q)))
    else $error("memory write outside an entry move or insert");

  a_cnt_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> ($past(state_q) == S_SCAN || $past(state_q) == S_WNEW))
    else $error("entry count changed outside a list update");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == S_FIN))
    else $error("result raised without a finished request");
`endif

endmodule
